### src/kma_pkg.sv
// shared types and constants of the k-means assignment and accumulation engine
package kma_pkg;

   localparam logic [1:0] REQ_LOAD   = 2'd0;
   localparam logic [1:0] REQ_SAMPLE = 2'd1;
   localparam logic [1:0] REQ_UPDATE = 2'd2;
   localparam logic [1:0] REQ_CLEAR  = 2'd3;

   localparam logic CSR_NUM_CLUSTERS = 1'b0;
   localparam logic CSR_DIM_IN_USE   = 1'b1;

   localparam logic KIND_ASSIGN   = 1'b0;
   localparam logic KIND_CENTROID = 1'b1;

   localparam int VALUE_W = 16;
   localparam int DIST_W  = 39;
   localparam int SUM_W   = 48;
   localparam int COUNT_W = 32;
   localparam int SQ_W    = 32;
   localparam int DCNT_W  = 6;

   localparam logic [4:0] NUM_CLUSTERS_RESET = 5'd1;
   localparam logic [6:0] DIM_IN_USE_RESET   = 7'd64;

   typedef enum logic [2:0] {
      OP_LOAD,
      OP_SAMPLE,
      OP_SAMPLE_LAST,
      OP_UPDATE,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      op_type                     op;
      logic [3:0]                 cluster;
      logic [5:0]                 element;
      logic signed [VALUE_W-1:0]  value;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_out_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_DIST,
      ST_SEARCH,
      ST_ACC,
      ST_UPD_RD,
      ST_UPD_CAP,
      ST_UPD_DIV,
      ST_UPD_WR,
      ST_EMIT
   } state_type;

endpackage

### src/kma_chan_if.sv
// request and response channel interfaces
interface kma_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         req_type;
   logic [3:0]         cluster_index;
   logic [5:0]         element_index;
   logic signed [15:0] value;

   modport source (output valid, req_type, cluster_index, element_index, value,
                   input ready);
   modport sink (input valid, req_type, cluster_index, element_index, value,
                 output ready);
endinterface

interface kma_rsp_if;
   logic               valid;
   logic               ready;
   logic               result_kind;
   logic [3:0]         best_cluster;
   logic [38:0]        min_distance;
   logic signed [15:0] centroid_value;
   logic               empty_cluster;

   modport source (output valid, result_kind, best_cluster, min_distance,
                   centroid_value, empty_cluster, input ready);
   modport sink (input valid, result_kind, best_cluster, min_distance,
                 centroid_value, empty_cluster, output ready);
endinterface

### src/kma_ram.sv
// generic single write, single read ram with registered read data
module kma_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/kma_front.sv
// front end: accepts request beats, drops ignored ones, queues commands
module kma_front #(
   parameter int MAX_CLUSTERS = 16,
   parameter int MAX_DIM      = 64,
   parameter int NDW          = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   kma_req_if.sink                req_chan,
   input  logic [NDW-1:0]         nd,
   input  logic                   hold,
   output kma_pkg::queue_out_type q_out,
   input  logic                   q_pop
);

   kma_pkg::cmd_type slot_ff [2];
   logic             rd_ptr_ff, rd_ptr_in;
   logic             wr_ptr_ff, wr_ptr_in;
   logic [1:0]       count_ff, count_in;

   logic             keep;
   logic             push;
   kma_pkg::cmd_type cmd;

   always_comb begin
      cmd.cluster = req_chan.cluster_index;
      cmd.element = req_chan.element_index;
      cmd.value   = req_chan.value;
      cmd.op      = kma_pkg::OP_LOAD;
      keep        = 1'b0;
      case (req_chan.req_type)
         kma_pkg::REQ_LOAD: begin
            cmd.op = kma_pkg::OP_LOAD;
            keep   = (int'(req_chan.cluster_index) < MAX_CLUSTERS)
                     && (int'(req_chan.element_index) < MAX_DIM);
         end
         kma_pkg::REQ_UPDATE: begin
            cmd.op = kma_pkg::OP_UPDATE;
            keep   = (int'(req_chan.cluster_index) < MAX_CLUSTERS)
                     && (int'(req_chan.element_index) < MAX_DIM);
         end
         kma_pkg::REQ_SAMPLE: begin
            keep   = int'(req_chan.element_index) < int'(nd);
            cmd.op = (int'(req_chan.element_index) == int'(nd) - 1)
                     ? kma_pkg::OP_SAMPLE_LAST : kma_pkg::OP_SAMPLE;
         end
         kma_pkg::REQ_CLEAR: begin
            cmd.op = kma_pkg::OP_CLEAR;
            keep   = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_chan.ready = (count_ff != 2'd2) && !hold;
   assign push           = req_chan.valid && req_chan.ready && keep;

   assign q_out.valid = count_ff != 2'd0;
   assign q_out.cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule

### src/kma_back.sv
// back end: distance pipeline, nearest search, accumulation, centroid divide
module kma_back #(
   parameter int MAX_CLUSTERS = 16,
   parameter int MAX_DIM      = 64,
   parameter int NCW          = 5,
   parameter int NDW          = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  kma_pkg::queue_out_type q_in,
   output logic                   q_pop,
   input  logic [NCW-1:0]         nc,
   input  logic [NDW-1:0]         nd,
   output logic                   init_busy,
   kma_rsp_if.source              rsp_chan
);

   localparam int DEPTH = MAX_CLUSTERS * MAX_DIM;
   localparam int KW    = MAX_CLUSTERS > 1 ? $clog2(MAX_CLUSTERS) : 1;
   localparam int EW    = MAX_DIM > 1 ? $clog2(MAX_DIM) : 1;
   localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int IW    = AW + 1;
   localparam int VW    = kma_pkg::VALUE_W;
   localparam int DW    = kma_pkg::DIST_W;
   localparam int SW    = kma_pkg::SUM_W;
   localparam int CW    = kma_pkg::COUNT_W;
   localparam int QW    = kma_pkg::SQ_W;

   function automatic logic [AW-1:0] addr_of(input logic [KW-1:0] k,
                                             input logic [EW-1:0] e);
      return AW'(k) * AW'(MAX_DIM) + AW'(e);
   endfunction

   kma_pkg::state_type state_ff, state_in;
   kma_pkg::cmd_type   cmd_ff;
   logic [IW-1:0]      idx_ff, idx_in;

   // distance pipeline
   logic               s1_v_ff, s2_v_ff;
   logic [KW-1:0]      s1_k_ff, s2_k_ff;
   logic [QW-1:0]      sq_ff;
   logic [DW-1:0]      pd_ff [MAX_CLUSTERS];
   logic [CW-1:0]      counts_ff [MAX_CLUSTERS];

   // search and accumulation
   logic [KW-1:0]      best_ff;
   logic [DW-1:0]      bestd_ff;
   logic [AW-1:0]      base_ff;
   logic               a1_v_ff;
   logic [AW-1:0]      a1_j_ff;

   // divider
   logic [SW-1:0]      dq_ff;
   logic [CW-1:0]      rem_ff;
   logic [CW-1:0]      den_ff;
   logic               neg_ff;
   logic [kma_pkg::DCNT_W-1:0] dcnt_ff;

   // result held for the output register
   logic               res_kind_ff;
   logic [3:0]         res_cluster_ff;
   logic [DW-1:0]      res_dist_ff;
   logic [VW-1:0]      res_cval_ff;
   logic               res_empty_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff;
   logic [3:0]         rsp_cluster_ff;
   logic [DW-1:0]      rsp_dist_ff;
   logic [VW-1:0]      rsp_cval_ff;
   logic               rsp_empty_ff;

   // ram ports
   logic               cent_we, sum_we, samp_we;
   logic [AW-1:0]      cent_waddr, cent_raddr, sum_waddr, sum_raddr;
   logic [EW-1:0]      samp_waddr, samp_raddr;
   logic [VW-1:0]      cent_wdata, samp_wdata, cent_rdata, samp_rdata;
   logic [SW-1:0]      sum_wdata, sum_rdata;

   logic               dist_issue, dist_done, acc_issue, acc_done, emit_ok;
   logic [KW-1:0]      cnt_sel;
   logic [CW-1:0]      sel_count;
   logic [AW-1:0]      upd_addr;
   logic [SW-1:0]      acc_sum;
   logic [VW-1:0]      q_sat;
   logic [KW-1:0]      pd_k;
   logic [VW:0]        diff;
   logic [2*VW+1:0]    diff_sq;
   logic [DW:0]        pd_sum;
   logic [CW:0]        trial;
   logic               trial_ge;

   kma_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_centroids (
      .clock  (clock),
      .wr_en  (cent_we),
      .wr_addr(cent_waddr),
      .wr_data(cent_wdata),
      .rd_addr(cent_raddr),
      .rd_data(cent_rdata)
   );

   kma_ram #(.WIDTH(SW), .DEPTH(DEPTH)) u_sums (
      .clock  (clock),
      .wr_en  (sum_we),
      .wr_addr(sum_waddr),
      .wr_data(sum_wdata),
      .rd_addr(sum_raddr),
      .rd_data(sum_rdata)
   );

   kma_ram #(.WIDTH(VW), .DEPTH(MAX_DIM)) u_sample (
      .clock  (clock),
      .wr_en  (samp_we),
      .wr_addr(samp_waddr),
      .wr_data(samp_wdata),
      .rd_addr(samp_raddr),
      .rd_data(samp_rdata)
   );

   assign dist_issue = (state_ff == kma_pkg::ST_DIST) && (idx_ff < IW'(nc));
   assign dist_done  = (state_ff == kma_pkg::ST_DIST) && !dist_issue
                       && !s1_v_ff && !s2_v_ff;
   assign acc_issue  = (state_ff == kma_pkg::ST_ACC) && (idx_ff < IW'(nd));
   assign acc_done   = (state_ff == kma_pkg::ST_ACC) && !acc_issue && !a1_v_ff;
   assign emit_ok    = !rsp_valid_ff || rsp_chan.ready;
   assign upd_addr   = addr_of(KW'(cmd_ff.cluster), EW'(cmd_ff.element));
   assign pd_k       = idx_ff[KW-1:0];

   assign cnt_sel   = (state_ff == kma_pkg::ST_ACC) ? best_ff : KW'(cmd_ff.cluster);
   assign sel_count = counts_ff[cnt_sel];

   // squared difference, saturating distance add, restoring divide step
   always_comb begin
      diff    = {cmd_ff.value[VW-1], cmd_ff.value}
                - {cent_rdata[VW-1], cent_rdata};
      diff_sq = $signed(diff) * $signed(diff);
      pd_sum  = {1'b0, pd_ff[s2_k_ff]} + (DW+1)'(sq_ff);
      trial    = {rem_ff, dq_ff[SW-1]};
      trial_ge = trial >= {1'b0, den_ff};
   end

   // saturating sum add and quotient clamp
   always_comb begin
      logic [SW:0] s;
      s = {sum_rdata[SW-1], sum_rdata}
          + {{(SW+1-VW){samp_rdata[VW-1]}}, samp_rdata};
      if (s[SW] != s[SW-1]) begin
         acc_sum = s[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
      end else begin
         acc_sum = s[SW-1:0];
      end
      if (!neg_ff) begin
         q_sat = (dq_ff > SW'(32767)) ? VW'(32767) : dq_ff[VW-1:0];
      end else begin
         q_sat = (dq_ff > SW'(32768)) ? {1'b1, {(VW-1){1'b0}}} : VW'(-dq_ff);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         kma_pkg::ST_INIT: begin
            if (idx_ff == IW'(DEPTH - 1)) state_in = kma_pkg::ST_IDLE;
         end
         kma_pkg::ST_IDLE: begin
            if (q_in.valid) begin
               case (q_in.cmd.op)
                  kma_pkg::OP_SAMPLE,
                  kma_pkg::OP_SAMPLE_LAST: state_in = kma_pkg::ST_DIST;
                  kma_pkg::OP_UPDATE:      state_in = kma_pkg::ST_UPD_RD;
                  kma_pkg::OP_CLEAR:       state_in = kma_pkg::ST_INIT;
                  default:                 state_in = kma_pkg::ST_IDLE;
               endcase
            end
         end
         kma_pkg::ST_DIST: begin
            if (dist_done) begin
               state_in = (cmd_ff.op == kma_pkg::OP_SAMPLE_LAST)
                          ? kma_pkg::ST_SEARCH : kma_pkg::ST_IDLE;
            end
         end
         kma_pkg::ST_SEARCH: begin
            if (idx_ff >= IW'(nc)) state_in = kma_pkg::ST_ACC;
         end
         kma_pkg::ST_ACC: begin
            if (acc_done) state_in = kma_pkg::ST_EMIT;
         end
         kma_pkg::ST_UPD_RD:  state_in = kma_pkg::ST_UPD_CAP;
         kma_pkg::ST_UPD_CAP: begin
            state_in = (sel_count == '0) ? kma_pkg::ST_EMIT : kma_pkg::ST_UPD_DIV;
         end
         kma_pkg::ST_UPD_DIV: begin
            if (dcnt_ff == kma_pkg::DCNT_W'(SW - 1)) state_in = kma_pkg::ST_UPD_WR;
         end
         kma_pkg::ST_UPD_WR: state_in = kma_pkg::ST_EMIT;
         kma_pkg::ST_EMIT: begin
            if (emit_ok) state_in = kma_pkg::ST_IDLE;
         end
         default: state_in = kma_pkg::ST_INIT;
      endcase
   end

   // ram and queue controls
   always_comb begin
      q_pop      = 1'b0;
      cent_we    = 1'b0;
      cent_waddr = upd_addr;
      cent_wdata = q_sat;
      cent_raddr = upd_addr;
      sum_we     = 1'b0;
      sum_waddr  = base_ff + a1_j_ff;
      sum_wdata  = acc_sum;
      sum_raddr  = upd_addr;
      samp_we    = 1'b0;
      samp_waddr = EW'(q_in.cmd.element);
      samp_wdata = q_in.cmd.value;
      samp_raddr = idx_ff[EW-1:0];
      init_busy  = 1'b0;
      case (state_ff)
         kma_pkg::ST_INIT: begin
            init_busy = 1'b1;
            sum_we    = 1'b1;
            sum_waddr = idx_ff[AW-1:0];
            sum_wdata = '0;
         end
         kma_pkg::ST_IDLE: begin
            q_pop      = q_in.valid;
            cent_waddr = addr_of(KW'(q_in.cmd.cluster), EW'(q_in.cmd.element));
            cent_wdata = q_in.cmd.value;
            cent_we    = q_in.valid && (q_in.cmd.op == kma_pkg::OP_LOAD);
            samp_we    = q_in.valid && ((q_in.cmd.op == kma_pkg::OP_SAMPLE)
                                        || (q_in.cmd.op == kma_pkg::OP_SAMPLE_LAST));
         end
         kma_pkg::ST_DIST: begin
            cent_raddr = addr_of(idx_ff[KW-1:0], EW'(cmd_ff.element));
         end
         kma_pkg::ST_ACC: begin
            sum_raddr = base_ff + idx_ff[AW-1:0];
            sum_we    = a1_v_ff;
         end
         kma_pkg::ST_UPD_WR: begin
            cent_we = 1'b1;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      case (state_ff)
         kma_pkg::ST_INIT:   idx_in = (state_in == kma_pkg::ST_IDLE) ? '0 : idx_ff + 1'b1;
         kma_pkg::ST_IDLE:   idx_in = '0;
         kma_pkg::ST_DIST: begin
            if (dist_issue) idx_in = idx_ff + 1'b1;
            else if (dist_done) idx_in = '0;
         end
         kma_pkg::ST_SEARCH: idx_in = (idx_ff < IW'(nc)) ? idx_ff + 1'b1 : '0;
         kma_pkg::ST_ACC:    idx_in = acc_issue ? idx_ff + 1'b1 : idx_ff;
         default:            idx_in = idx_ff;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if ((state_ff == kma_pkg::ST_EMIT) && emit_ok) rsp_valid_in = 1'b1;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kma_pkg::ST_INIT;
         idx_ff       <= '0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         a1_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_CLUSTERS; i++) begin
            pd_ff[i]     <= '0;
            counts_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         s1_v_ff      <= dist_issue;
         s2_v_ff      <= s1_v_ff;
         a1_v_ff      <= acc_issue;
         rsp_valid_ff <= rsp_valid_in;
         if (s2_v_ff) begin
            pd_ff[s2_k_ff] <= pd_sum[DW] ? {DW{1'b1}} : pd_sum[DW-1:0];
         end
         if ((state_ff == kma_pkg::ST_IDLE) && q_in.valid
             && (q_in.cmd.op == kma_pkg::OP_CLEAR)) begin
            for (int i = 0; i < MAX_CLUSTERS; i++) begin
               pd_ff[i]     <= '0;
               counts_ff[i] <= '0;
            end
         end
         if (acc_done) begin
            // sample closed: bump its cluster and start the next one afresh
            if (sel_count != {CW{1'b1}}) counts_ff[best_ff] <= sel_count + 1'b1;
            for (int i = 0; i < MAX_CLUSTERS; i++) begin
               pd_ff[i] <= '0;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if ((state_ff == kma_pkg::ST_IDLE) && q_in.valid) cmd_ff <= q_in.cmd;
      s1_k_ff <= idx_ff[KW-1:0];
      s2_k_ff <= s1_k_ff;
      sq_ff   <= diff_sq[QW-1:0];
      a1_j_ff <= idx_ff[AW-1:0];
      case (state_ff)
         kma_pkg::ST_SEARCH: begin
            if (idx_ff < IW'(nc)) begin
               if ((idx_ff == '0) || (pd_ff[pd_k] < bestd_ff)) begin
                  best_ff  <= pd_k;
                  bestd_ff <= pd_ff[pd_k];
                  base_ff  <= addr_of(pd_k, '0);
               end
            end
         end
         kma_pkg::ST_ACC: begin
            res_kind_ff    <= kma_pkg::KIND_ASSIGN;
            res_cluster_ff <= 4'(best_ff);
            res_dist_ff    <= bestd_ff;
            res_cval_ff    <= '0;
            res_empty_ff   <= 1'b0;
         end
         kma_pkg::ST_UPD_CAP: begin
            res_kind_ff    <= kma_pkg::KIND_CENTROID;
            res_cluster_ff <= cmd_ff.cluster;
            res_dist_ff    <= '0;
            res_cval_ff    <= cent_rdata;
            res_empty_ff   <= sel_count == '0;
            neg_ff         <= sum_rdata[SW-1];
            dq_ff          <= sum_rdata[SW-1] ? -sum_rdata : sum_rdata;
            rem_ff         <= '0;
            den_ff         <= sel_count;
            dcnt_ff        <= '0;
         end
         kma_pkg::ST_UPD_DIV: begin
            rem_ff  <= trial_ge ? CW'(trial - {1'b0, den_ff}) : trial[CW-1:0];
            dq_ff   <= {dq_ff[SW-2:0], trial_ge};
            dcnt_ff <= dcnt_ff + 1'b1;
         end
         kma_pkg::ST_UPD_WR: begin
            res_cval_ff <= q_sat;
         end
         default: begin
            dcnt_ff <= dcnt_ff;
         end
      endcase
      if ((state_ff == kma_pkg::ST_EMIT) && emit_ok) begin
         rsp_kind_ff    <= res_kind_ff;
         rsp_cluster_ff <= res_cluster_ff;
         rsp_dist_ff    <= res_dist_ff;
         rsp_cval_ff    <= res_cval_ff;
         rsp_empty_ff   <= res_empty_ff;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.result_kind    = rsp_kind_ff;
   assign rsp_chan.best_cluster   = rsp_cluster_ff;
   assign rsp_chan.min_distance   = rsp_dist_ff;
   assign rsp_chan.centroid_value = rsp_cval_ff;
   assign rsp_chan.empty_cluster  = rsp_empty_ff;

endmodule

### src/kmeans_assign_accumulate.sv
// top level of the k-means assignment and accumulation engine
//
//  channel   dir  handshake        beat
//  req_chan  in   valid / ready    one load, sample, update or clear item
//  rsp_chan  out  valid / ready    one assignment or centroid result
//  csr_*     in   csr_we only      one register write
//
// load writes the centroid store; each sample element runs through the shared multiplier
// for every cluster in use; the closing element adds the nearest search and the sum
// update, then the result; an update runs the 48-step restoring divider.
// reset and clear sweep the sum memory, all MAX_CLUSTERS * MAX_DIM entries, with
// req_chan held not ready. a two-entry queue lets the front take beats while
// the back works, and the output register holds one result under stall.
module kmeans_assign_accumulate #(
   parameter int MAX_CLUSTERS = 16,
   parameter int MAX_DIM      = 64
) (
   input  logic       clock,
   input  logic       reset,
   kma_req_if.sink    req_chan,
   kma_rsp_if.source  rsp_chan,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [6:0] csr_wdata
);

   localparam int NCW = $clog2(MAX_CLUSTERS + 1);
   localparam int NDW = $clog2(MAX_DIM + 1);

   logic [4:0]             num_clusters_ff;
   logic [6:0]             dim_in_use_ff;
   logic [NCW-1:0]         nc;
   logic [NDW-1:0]         nd;
   kma_pkg::queue_out_type q_out;
   logic                   q_pop;
   logic                   init_busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_clusters_ff <= kma_pkg::NUM_CLUSTERS_RESET;
         dim_in_use_ff   <= kma_pkg::DIM_IN_USE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            kma_pkg::CSR_NUM_CLUSTERS: num_clusters_ff <= csr_wdata[4:0];
            kma_pkg::CSR_DIM_IN_USE:   dim_in_use_ff   <= csr_wdata;
            default:                   dim_in_use_ff   <= dim_in_use_ff;
         endcase
      end
   end

   // clamp the registers into the range the store supports
   always_comb begin
      if (num_clusters_ff == '0) nc = NCW'(1);
      else if (int'(num_clusters_ff) > MAX_CLUSTERS) nc = NCW'(MAX_CLUSTERS);
      else nc = NCW'(num_clusters_ff);
      if (dim_in_use_ff == '0) nd = NDW'(1);
      else if (int'(dim_in_use_ff) > MAX_DIM) nd = NDW'(MAX_DIM);
      else nd = NDW'(dim_in_use_ff);
   end

   kma_front #(.MAX_CLUSTERS(MAX_CLUSTERS), .MAX_DIM(MAX_DIM), .NDW(NDW)) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .nd      (nd),
      .hold    (init_busy),
      .q_out   (q_out),
      .q_pop   (q_pop)
   );

   kma_back #(.MAX_CLUSTERS(MAX_CLUSTERS), .MAX_DIM(MAX_DIM), .NCW(NCW), .NDW(NDW))
   u_back (
      .clock    (clock),
      .reset    (reset),
      .q_in     (q_out),
      .q_pop    (q_pop),
      .nc       (nc),
      .nd       (nd),
      .init_busy(init_busy),
      .rsp_chan (rsp_chan)
   );

   a_assign_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.result_kind == kma_pkg::KIND_ASSIGN)
      |-> (rsp_chan.centroid_value == '0) && !rsp_chan.empty_cluster)
      else $error("assignment result carries centroid fields");

   a_update_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.result_kind == kma_pkg::KIND_CENTROID)
      |-> rsp_chan.min_distance == '0)
      else $error("centroid result carries a distance");

   a_best_in_use: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.result_kind == kma_pkg::KIND_ASSIGN)
      |-> int'(rsp_chan.best_cluster) < int'(nc))
      else $error("nearest cluster outside the clusters in use");

   a_no_pop_in_init: assert property (@(posedge clock) disable iff (reset)
      init_busy |-> !q_pop)
      else $error("command taken during memory sweep");

endmodule

### dv/kma_checker.sv
// checker: watches both channels and the register port, predicts and compares results
module kma_checker
   import kma_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   kma_req_if         req,
   kma_rsp_if         rsp,
   input  logic       csr_we,
   input  logic       csr_index,
   input  logic [6:0] csr_wdata,
   output int         errors,
   output int         pending,
   output int         n_assign,
   output int         n_centroid
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NCL = 16;
   localparam int NDIM = 64;
   localparam longint DIST_SAT = 64'h7F_FFFF_FFFF;
   localparam longint SUM_HI = 64'sh7FFF_FFFF_FFFF;
   localparam longint SUM_LO = -64'sh7FFF_FFFF_FFFF - 1;

   typedef struct {
      logic              kind;
      logic [3:0]        cluster;
      logic [38:0]       distance;
      logic signed [15:0] cval;
      logic              empty;
   } outcome_t;

   outcome_t outcomes[$];

   logic [4:0]         reg_nc;
   logic [6:0]         reg_nd;
   logic signed [15:0] centroids[NCL*NDIM];
   longint             sums[NCL*NDIM];
   longint unsigned    counts[NCL];
   longint             dists[NCL];
   logic signed [15:0] sample_buf[NDIM];

   function automatic int clusters_in_use();
      if (reg_nc == 0) return 1;
      if (reg_nc > NCL) return NCL;
      return int'(reg_nc);
   endfunction

   function automatic int dims_in_use();
      if (reg_nd == 0) return 1;
      if (reg_nd > NDIM) return NDIM;
      return int'(reg_nd);
   endfunction

   function automatic void clear_accum();
      foreach (sums[i]) sums[i] = 0;
      foreach (counts[i]) counts[i] = 0;
      foreach (dists[i]) dists[i] = 0;
   endfunction

   // applies one accepted request beat to the predicted state
   function automatic void predict_beat(logic [1:0] kind, logic [3:0] cl, logic [5:0] el,
                                        logic signed [15:0] val);
      int       a;
      int       nc;
      int       nd;
      int       best;
      longint   d;
      longint   s;
      longint   q;
      outcome_t o;
      a = int'(cl) * NDIM + int'(el);
      nc = clusters_in_use();
      nd = dims_in_use();
      case (kind)
         REQ_CLEAR: clear_accum();
         REQ_LOAD: centroids[a] = val;
         REQ_UPDATE: begin
            o.kind = KIND_CENTROID;
            o.cluster = cl;
            o.distance = '0;
            if (counts[cl] == 0) begin
               o.empty = 1'b1;
               o.cval = centroids[a];
            end else begin
               q = sums[a] / longint'(counts[cl]);
               if (q > 32767) q = 32767;
               if (q < -32768) q = -32768;
               centroids[a] = q[15:0];
               o.empty = 1'b0;
               o.cval = q[15:0];
            end
            outcomes.push_back(o);
         end
         default: begin
            if (int'(el) >= nd) return;
            sample_buf[el] = val;
            for (int k = 0; k < nc; k++) begin
               d = longint'(val) - longint'(centroids[k*NDIM + int'(el)]);
               s = dists[k] + d * d;
               dists[k] = (s > DIST_SAT) ? DIST_SAT : s;
            end
            if (int'(el) != nd - 1) return;
            best = 0;
            for (int k = 1; k < nc; k++)
               if (dists[k] < dists[best]) best = k;
            for (int j = 0; j < nd; j++) begin
               s = sums[best*NDIM + j] + longint'(sample_buf[j]);
               if (s > SUM_HI) s = SUM_HI;
               if (s < SUM_LO) s = SUM_LO;
               sums[best*NDIM + j] = s;
            end
            if (counts[best] != 64'hFFFF_FFFF) counts[best]++;
            o.kind = KIND_ASSIGN;
            o.cluster = best[3:0];
            o.distance = dists[best][38:0];
            o.cval = '0;
            o.empty = 1'b0;
            foreach (dists[i]) dists[i] = 0;
            outcomes.push_back(o);
         end
      endcase
   endfunction

   always @(posedge clock) begin
      outcome_t want;
      if (reset) begin
         reg_nc = NUM_CLUSTERS_RESET;
         reg_nd = DIM_IN_USE_RESET;
         foreach (centroids[i]) centroids[i] = '0;
         foreach (sample_buf[i]) sample_buf[i] = '0;
         clear_accum();
      end else begin
         if (csr_we) begin
            if (csr_index == CSR_NUM_CLUSTERS) reg_nc = csr_wdata[4:0];
            else reg_nd = csr_wdata;
         end
         if (req.valid && req.ready)
            predict_beat(req.req_type, req.cluster_index, req.element_index, req.value);
         if (rsp.valid && rsp.ready) begin
            if (outcomes.size() == 0) begin
               $error("result beat with nothing expected: kind %0d cluster %0d",
                      rsp.result_kind, rsp.best_cluster);
               errors++;
            end else begin
               want = outcomes.pop_front();
               if (rsp.result_kind === KIND_ASSIGN) n_assign++;
               else n_centroid++;
               if (rsp.result_kind !== want.kind) begin
                  $error("result_kind: expected %0d, got %0d", want.kind, rsp.result_kind);
                  errors++;
               end
               if (rsp.best_cluster !== want.cluster) begin
                  $error("best_cluster: expected %0d, got %0d", want.cluster,
                         rsp.best_cluster);
                  errors++;
               end
               if (rsp.min_distance !== want.distance) begin
                  $error("min_distance: expected %0d, got %0d", want.distance,
                         rsp.min_distance);
                  errors++;
               end
               if (rsp.centroid_value !== want.cval) begin
                  $error("centroid_value: expected %0d, got %0d", want.cval,
                         rsp.centroid_value);
                  errors++;
               end
               if (rsp.empty_cluster !== want.empty) begin
                  $error("empty_cluster: expected %0d, got %0d", want.empty,
                         rsp.empty_cluster);
                  errors++;
               end
            end
         end
      end
      pending = outcomes.size();
   end

   initial begin
      errors = 0;
      pending = 0;
      n_assign = 0;
      n_centroid = 0;
   end

endmodule

### dv/tb_top.sv
// testbench top: clock, reset, stimulus and verdict for the k-means engine
module tb_top;
   import kma_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1500000;
   localparam int SETTLE = 1200;

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic       csr_index;
   logic [6:0] csr_wdata;
   int         errors;
   int         pending;
   int         n_assign;
   int         n_centroid;
   int         idle_pct;
   int         stall_pct;
   int         cur_nd;
   int         items;
   int         cycles;

   kma_req_if req_chan ();
   kma_rsp_if rsp_chan ();

   kmeans_assign_accumulate u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   kma_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .rsp        (rsp_chan),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .errors     (errors),
      .pending    (pending),
      .n_assign   (n_assign),
      .n_centroid (n_centroid)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL kmeans_assign_accumulate");
         $finish;
      end
   end

   // one beat; valid stays high afterwards so back-to-back beats need no gap
   task automatic send(logic [1:0] kind, logic [3:0] cl, logic [5:0] el,
                       logic signed [15:0] val);
      while ($urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.req_type <= kind;
      req_chan.cluster_index <= cl;
      req_chan.element_index <= el;
      req_chan.value <= val;
      do @(posedge clock); while (!req_chan.ready);
      if (kind == REQ_UPDATE || (kind == REQ_SAMPLE && int'(el) < cur_nd)) items++;
   endtask

   // hold the sender until every result is in and the back end has drained
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_config(logic [4:0] nc, logic [6:0] nd);
      drain();
      csr_we <= 1'b1;
      csr_index <= CSR_NUM_CLUSTERS;
      csr_wdata <= {2'b00, nc};
      @(posedge clock);
      csr_index <= CSR_DIM_IN_USE;
      csr_wdata <= nd;
      @(posedge clock);
      csr_we <= 1'b0;
      cur_nd = (nd == 0) ? 1 : (nd > 64) ? 64 : int'(nd);
   endtask

   // one sample, mostly well formed; sometimes skips, repeats or strays past the end
   task automatic sample_seq(bit noisy);
      for (int e = 0; e < cur_nd; e++) begin
         if (noisy && $urandom_range(9) == 0 && e != cur_nd - 1) continue;
         if (noisy && $urandom_range(19) == 0)
            send(REQ_SAMPLE, 4'($urandom), e[5:0], 16'($urandom));
         if (noisy && cur_nd < 64 && $urandom_range(19) == 0)
            send(REQ_SAMPLE, 4'($urandom), 6'($urandom_range(63, cur_nd)),
                 16'($urandom));
         send(REQ_SAMPLE, 4'($urandom), e[5:0], 16'($urandom));
      end
   endtask

   task automatic update_sweep(logic [3:0] cl);
      for (int e = 0; e < cur_nd; e++) send(REQ_UPDATE, cl, e[5:0], 16'($urandom));
   endtask

   initial begin
      int pick;
      req_chan.valid = 1'b0;
      req_chan.req_type = REQ_LOAD;
      req_chan.cluster_index = '0;
      req_chan.element_index = '0;
      req_chan.value = '0;
      rsp_chan.ready = 1'b0;
      csr_we = 1'b0;
      csr_index = CSR_NUM_CLUSTERS;
      csr_wdata = '0;
      cycles = 0;
      items = 0;
      idle_pct = 0;
      stall_pct = 0;
      cur_nd = 64;
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // fill the whole centroid store so no unwritten entry is ever read
      for (int a = 0; a < 1024; a++)
         send(REQ_LOAD, a[9:6], a[5:0], 16'($urandom));
      send(REQ_LOAD, 4'd0, 6'd0, -16'sd32768);
      send(REQ_LOAD, 4'd15, 6'd63, 16'sd32767);

      // first sample writes every buffer entry; element 0 repeated to saturate distance
      for (int r = 0; r < 130; r++) send(REQ_SAMPLE, 4'd0, 6'd0, 16'sd32767);
      for (int e = 1; e < 64; e++) send(REQ_SAMPLE, 4'd0, e[5:0], 16'($urandom));
      send(REQ_UPDATE, 4'd0, 6'd0, 16'sd0);
      send(REQ_UPDATE, 4'd0, 6'd63, 16'sd0);
      send(REQ_UPDATE, 4'd5, 6'd3, 16'sd0);
      send(REQ_CLEAR, 4'd0, 6'd0, 16'sd0);
      send(REQ_UPDATE, 4'd0, 6'd0, 16'sd0);

      // tie between clusters one and two on a single element
      set_config(5'd16, 7'd1);
      for (int c = 0; c < 16; c++)
         send(REQ_LOAD, c[3:0], 6'd0, (c == 0) ? -16'sd32768 : 16'sd32767);
      send(REQ_LOAD, 4'd1, 6'd0, 16'sd100);
      send(REQ_LOAD, 4'd2, 6'd0, 16'sd100);
      send(REQ_SAMPLE, 4'd0, 6'd0, 16'sd100);
      send(REQ_SAMPLE, 4'd0, 6'd0, -16'sd32768);
      send(REQ_UPDATE, 4'd1, 6'd0, 16'sd0);
      send(REQ_UPDATE, 4'd2, 6'd0, 16'sd0);

      items = 0;
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: set_config(5'd16, 7'd64);
            1: set_config(5'd3, 7'd5);
            2: set_config(5'd16, 7'd4);
            3: set_config(5'd0, 7'd7);
            4: set_config(5'd31, 7'd3);
            5: set_config(5'd5, 7'd0);
            6: set_config(5'd8, 7'd127);
            default: set_config(5'd16, 7'd2);
         endcase
         case (ph % 4)
            0: begin idle_pct = 0; stall_pct = 0; end
            1: begin idle_pct = 74; stall_pct = 0; end
            2: begin idle_pct = 0; stall_pct = 74; end
            default: begin idle_pct = 30; stall_pct = 30; end
         endcase
         send(REQ_CLEAR, 4'($urandom), 6'($urandom), 16'($urandom));
         while (items < (ph + 1) * 50) begin
            pick = $urandom_range(99);
            if (pick < 70) sample_seq(pick < 20);
            else if (pick < 78) update_sweep(4'($urandom));
            else if (pick < 85) send(REQ_UPDATE, 4'($urandom),
                                     6'($urandom_range(cur_nd - 1)), 16'($urandom));
            else if (pick < 93) send(REQ_LOAD, 4'($urandom), 6'($urandom), 16'($urandom));
            else if (pick < 95) send(REQ_CLEAR, 4'($urandom), 6'($urandom), 16'($urandom));
            else send(2'($urandom), 4'($urandom), 6'($urandom), 16'($urandom));
         end
      end

      drain();
      $display("covered %0d assignments and %0d centroid updates over eight settings",
               n_assign, n_centroid);
      $display("with idle and stall mixes, ties, distance saturation and empty clusters");
      if (errors == 0) begin
         $display("PASS kmeans_assign_accumulate");
      end else begin
         $display("FAIL kmeans_assign_accumulate");
      end
      $finish;
   end

endmodule
